### rtl/multi_mode_moving_average_macros.svh
// assertion macros shared by the moving average checker
`ifndef MULTI_MODE_MOVING_AVERAGE_MACROS_SVH
`define MULTI_MODE_MOVING_AVERAGE_MACROS_SVH

// clocked check, off while reset is asserted
`define MMA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// clocked check that also holds during reset
`define MMA_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

### rtl/mma_pkg.sv
// shared types, codes and constants of the moving average block
package mma_pkg;

  localparam int MAX_PERIOD_DEF = 256;
  localparam int DATA_W         = 32;
  localparam int PERIOD_W       = 9;
  localparam int METHOD_W       = 2;
  localparam int CFG_IDX_W      = 2;
  localparam int CFG_DATA_W     = 9;
  localparam int EMA_W          = 17;
  localparam int EMA_SHIFT      = 16;

  localparam logic [CFG_IDX_W-1:0]  CFG_PERIOD   = 2'd0;
  localparam logic [CFG_IDX_W-1:0]  CFG_METHOD   = 2'd1;
  localparam logic [PERIOD_W-1:0]   PERIOD_RESET = 9'd13;
  localparam logic [17:0]           EMA_NUM      = 18'd131072;
  localparam logic [EMA_W-1:0]      EMA_ONE      = 17'd65536;

  typedef enum logic [METHOD_W-1:0] {
    METH_SMA  = 2'd0,
    METH_EMA  = 2'd1,
    METH_SMMA = 2'd2,
    METH_LWMA = 2'd3
  } method_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PREP,
    ST_SUM,
    ST_DRAIN1,
    ST_DRAIN2,
    ST_MUL1,
    ST_MUL2,
    ST_DSTART,
    ST_DWAIT,
    ST_FINISH
  } state_e;

  typedef enum logic [1:0] {
    DIV_SUM,
    DIV_WSUM,
    DIV_EMA,
    DIV_SMMA
  } div_sel_e;

  typedef enum logic [1:0] {
    MUL_XA,
    MUL_LA,
    MUL_SMMA
  } mul_sel_e;

  typedef enum logic [1:0] {
    RES_X,
    RES_ZERO,
    RES_QUOT,
    RES_EMA
  } res_sel_e;

  typedef struct packed {
    logic     accept;
    logic     sum_start;
    logic     sum_step;
    logic     div_start;
    div_sel_e div_sel;
    logic     mul_en;
    mul_sel_e mul_sel;
    logic     load_out;
    res_sel_e res_sel;
  } cmd_t;

  typedef struct packed {
    method_e method;
    logic    n_zero;
    logic    n_lt_p;
    logic    n_eq_p;
    logic    rd_last;
    logic    div_busy;
    logic    out_free;
  } stat_t;

endpackage

### rtl/mma_div.sv
// restoring divider, one quotient bit per cycle
module mma_div #(
  parameter int NumW = 48,
  parameter int DenW = 16
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic [NumW-1:0] num_i,
  input  logic [DenW-1:0] den_i,
  output logic            busy_o,
  output logic [NumW-1:0] quot_o
);

  localparam int CntW = $clog2(NumW + 1);

  logic [CntW-1:0] cnt_q, cnt_d;
  logic [NumW-1:0] num_q, num_d;
  logic [DenW-1:0] rem_q, rem_d;
  logic [DenW-1:0] den_q, den_d;
  logic [DenW:0]   trial;
  logic [DenW:0]   diff;
  logic            ge;

  assign trial = {rem_q, num_q[NumW-1]};
  assign ge    = trial >= {1'b0, den_q};
  assign diff  = trial - {1'b0, den_q};

  always_comb begin
    cnt_d = cnt_q;
    num_d = num_q;
    rem_d = rem_q;
    den_d = den_q;
    if (start_i) begin
      cnt_d = CntW'(NumW);
      num_d = num_i;
      rem_d = '0;
      den_d = den_i;
    end else if (cnt_q != '0) begin
      cnt_d = cnt_q - CntW'(1);
      num_d = {num_q[NumW-2:0], ge};
      rem_d = ge ? diff[DenW-1:0] : trial[DenW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    rem_q <= rem_d;
    den_q <= den_d;
  end

  assign busy_o = cnt_q != '0;
  assign quot_o = num_q;

endmodule

### rtl/mma_ctrl.sv
// sequencing state machine of the moving average block
module mma_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          sample_valid_i,
  output logic          sample_ready_o,
  input  mma_pkg::stat_t stat_i,
  output mma_pkg::cmd_t  cmd_o
);

  import mma_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d        = state_q;
    cmd_o          = '0;
    sample_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        sample_ready_o = 1'b1;
        if (sample_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d      = ST_PREP;
        end
      end
      ST_PREP: begin
        case (stat_i.method)
          METH_EMA: begin
            state_d = stat_i.n_zero ? ST_FINISH : ST_DSTART;
          end
          METH_SMMA: begin
            if (stat_i.n_lt_p) begin
              state_d = ST_FINISH;
            end else if (stat_i.n_eq_p) begin
              cmd_o.sum_start = 1'b1;
              state_d         = ST_SUM;
            end else begin
              state_d = ST_MUL1;
            end
          end
          default: begin
            if (stat_i.n_lt_p) begin
              state_d = ST_FINISH;
            end else begin
              cmd_o.sum_start = 1'b1;
              state_d         = ST_SUM;
            end
          end
        endcase
      end
      ST_SUM: begin
        cmd_o.sum_step = 1'b1;
        if (stat_i.rd_last) begin
          state_d = ST_DRAIN1;
        end
      end
      ST_DRAIN1: begin
        state_d = ST_DRAIN2;
      end
      ST_DRAIN2: begin
        state_d = ST_DSTART;
      end
      ST_DSTART: begin
        cmd_o.div_start = 1'b1;
        case (stat_i.method)
          METH_SMA:  cmd_o.div_sel = DIV_SUM;
          METH_EMA:  cmd_o.div_sel = DIV_EMA;
          METH_SMMA: cmd_o.div_sel = stat_i.n_eq_p ? DIV_SUM : DIV_SMMA;
          default:   cmd_o.div_sel = DIV_WSUM;
        endcase
        state_d = ST_DWAIT;
      end
      ST_DWAIT: begin
        if (!stat_i.div_busy) begin
          state_d = (stat_i.method == METH_EMA) ? ST_MUL1 : ST_FINISH;
        end
      end
      ST_MUL1: begin
        cmd_o.mul_en = 1'b1;
        if (stat_i.method == METH_EMA) begin
          cmd_o.mul_sel = MUL_XA;
          state_d       = ST_MUL2;
        end else begin
          cmd_o.mul_sel = MUL_SMMA;
          state_d       = ST_DSTART;
        end
      end
      ST_MUL2: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = MUL_LA;
        state_d       = ST_FINISH;
      end
      ST_FINISH: begin
        if (stat_i.method inside {METH_SMA, METH_LWMA}) begin
          cmd_o.res_sel = stat_i.n_lt_p ? RES_X : RES_QUOT;
        end else if (stat_i.method == METH_EMA) begin
          cmd_o.res_sel = stat_i.n_zero ? RES_X : RES_EMA;
        end else begin
          cmd_o.res_sel = stat_i.n_lt_p ? RES_ZERO : RES_QUOT;
        end
        if (stat_i.out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

### rtl/mma_dp.sv
// datapath: config, sample window, sums, multiplier, divider and output register
module mma_dp #(
  parameter int MaxPeriod = mma_pkg::MAX_PERIOD_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [mma_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [mma_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  input  logic [mma_pkg::DATA_W-1:0]       sample_i,
  output logic                             result_valid_o,
  input  logic                             result_ready_i,
  output logic [mma_pkg::DATA_W-1:0]       average_o,
  output logic                             falling_o,
  input  mma_pkg::cmd_t                    cmd_i,
  output mma_pkg::stat_t                   stat_o
);

  import mma_pkg::*;

  localparam int AW   = $clog2(MaxPeriod);
  localparam int PW   = $clog2(MaxPeriod + 1);
  localparam int CW   = $clog2(MaxPeriod + 2);
  localparam int WMAX = MaxPeriod * (MaxPeriod + 1) / 2;
  localparam int DVW  = $clog2(WMAX + 1);
  localparam int SW   = DATA_W + $clog2(MaxPeriod + 1);
  localparam int NW   = DATA_W + DVW;
  localparam int MBW  = (PW > EMA_W) ? PW : EMA_W;
  localparam int MW   = DATA_W + MBW;
  localparam int PRW  = (MW + 1 > NW) ? MW + 1 : NW;

  logic [PERIOD_W-1:0] period_q;
  method_e             method_q;

  logic [DATA_W-1:0]   mem [MaxPeriod];
  logic [DATA_W-1:0]   mem_rd_q;
  logic                rd_vld_q, acc_vld_q;

  logic [AW-1:0]       wp_q, newest_q, raddr_q;
  logic [PW-1:0]       rcnt_q;
  logic [CW-1:0]       bar_q, n_q;
  logic [PW-1:0]       p_eff, p_q;
  method_e             meth_q;
  logic [DATA_W-1:0]   x_q, last_q;
  logic [SW-1:0]       s_q;
  logic [NW-1:0]       wsum_q;
  logic [PRW-1:0]      prod_q;

  logic [2*PW:0]       pp;
  logic [DVW-1:0]      wden;
  logic [NW-1:0]       div_num;
  logic [DVW-1:0]      div_den;
  logic [NW-1:0]       quot;
  logic                div_busy;

  logic [EMA_W-1:0]    ema_a;
  logic [DATA_W-1:0]   mul_a;
  logic [MBW-1:0]      mul_b;
  logic [MW-1:0]       mul_p;
  logic [PRW-1:0]      mul_add;

  logic [DATA_W-1:0]   res;
  logic [DATA_W-1:0]   avg_q;
  logic                fall_q, out_vld_q;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      period_q <= PERIOD_RESET;
      method_q <= METH_SMA;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_PERIOD: period_q <= cfg_data_i[PERIOD_W-1:0];
        CFG_METHOD: method_q <= method_e'(cfg_data_i[METHOD_W-1:0]);
        default:    ;
      endcase
    end
  end

  always_comb begin
    if (period_q == '0) begin
      p_eff = PW'(1);
    end else if (32'(period_q) > 32'(MaxPeriod)) begin
      p_eff = PW'(MaxPeriod);
    end else begin
      p_eff = PW'(period_q);
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q      <= '0;
      bar_q     <= '0;
      last_q    <= '0;
      rd_vld_q  <= 1'b0;
      acc_vld_q <= 1'b0;
      rcnt_q    <= '0;
      out_vld_q <= 1'b0;
    end else begin
      rd_vld_q  <= cmd_i.sum_step;
      acc_vld_q <= rd_vld_q;
      if (cmd_i.accept) begin
        wp_q <= (wp_q == AW'(MaxPeriod - 1)) ? '0 : wp_q + AW'(1);
        if (bar_q != CW'(MaxPeriod + 1)) begin
          bar_q <= bar_q + CW'(1);
        end
      end
      if (cmd_i.sum_start) begin
        rcnt_q <= p_q;
      end else if (cmd_i.sum_step) begin
        rcnt_q <= rcnt_q - PW'(1);
      end
      if (cmd_i.load_out) begin
        last_q    <= res;
        out_vld_q <= 1'b1;
      end else if (result_ready_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // sample window
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      mem[wp_q] <= sample_i;
    end
    if (cmd_i.sum_step) begin
      mem_rd_q <= mem[raddr_q];
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      x_q      <= sample_i;
      p_q      <= p_eff;
      meth_q   <= method_q;
      n_q      <= bar_q;
      newest_q <= wp_q;
      s_q      <= '0;
      wsum_q   <= '0;
    end else begin
      if (rd_vld_q) begin
        s_q <= s_q + SW'(mem_rd_q);
      end
      if (acc_vld_q) begin
        wsum_q <= wsum_q + NW'(s_q);
      end
    end
    if (cmd_i.sum_start) begin
      raddr_q <= newest_q;
    end else if (cmd_i.sum_step) begin
      raddr_q <= (raddr_q == '0) ? AW'(MaxPeriod - 1) : raddr_q - AW'(1);
    end
    if (cmd_i.mul_en) begin
      prod_q <= PRW'(mul_p) + mul_add;
    end
    if (cmd_i.load_out) begin
      avg_q  <= res;
      fall_q <= res < last_q;
    end
  end

  // weight total p*(p+1)/2
  assign pp   = (2*PW+1)'(p_q) * (2*PW+1)'({1'b0, p_q} + (PW+1)'(1));
  assign wden = DVW'(pp >> 1);

  always_comb begin
    case (cmd_i.div_sel)
      DIV_SUM: begin
        div_num = NW'(s_q);
        div_den = DVW'(p_q);
      end
      DIV_WSUM: begin
        div_num = wsum_q;
        div_den = wden;
      end
      DIV_EMA: begin
        div_num = NW'(EMA_NUM);
        div_den = DVW'(p_q) + DVW'(1);
      end
      default: begin
        div_num = NW'(prod_q);
        div_den = DVW'(p_q);
      end
    endcase
  end

  mma_div #(
    .NumW (NW),
    .DenW (DVW)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .busy_o  (div_busy),
    .quot_o  (quot)
  );

  assign ema_a = quot[EMA_W-1:0];

  always_comb begin
    case (cmd_i.mul_sel)
      MUL_XA: begin
        mul_a   = x_q;
        mul_b   = MBW'(ema_a);
        mul_add = '0;
      end
      MUL_LA: begin
        mul_a   = last_q;
        mul_b   = MBW'(EMA_ONE - ema_a);
        mul_add = prod_q;
      end
      default: begin
        mul_a   = last_q;
        mul_b   = MBW'(p_q - PW'(1));
        mul_add = PRW'(x_q);
      end
    endcase
  end

  assign mul_p = MW'(mul_a) * MW'(mul_b);

  always_comb begin
    case (cmd_i.res_sel)
      RES_X:    res = x_q;
      RES_ZERO: res = '0;
      RES_QUOT: res = quot[DATA_W-1:0];
      default:  res = prod_q[EMA_SHIFT +: DATA_W];
    endcase
  end

  assign stat_o.method   = meth_q;
  assign stat_o.n_zero   = n_q == '0;
  assign stat_o.n_lt_p   = n_q < CW'(p_q);
  assign stat_o.n_eq_p   = n_q == CW'(p_q);
  assign stat_o.rd_last  = rcnt_q == PW'(1);
  assign stat_o.div_busy = div_busy;
  assign stat_o.out_free = !out_vld_q || result_ready_i;

  assign result_valid_o = out_vld_q;
  assign average_o      = avg_q;
  assign falling_o      = fall_q;

endmodule

### rtl/multi_mode_moving_average.sv
// top level of the multi-mode moving average
//
//   channel   direction  handshake                      payload
//   sample    in         sample_valid_i/sample_ready_o  sample_i
//   result    out        result_valid_o/result_ready_i  average_o, falling_o
//   config    in         cfg_we_i                       cfg_idx_i, cfg_data_i
//
// one bar in flight; a new sample is taken while the previous result waits
// pass-through bars go straight to FINISH; windowed bars sum the last p samples (p the
// period) and divide; exponential bars divide, then multiply; later smoothed bars multiply,
// then divide, on a bit-serial divider of NW = 32 + clog2(WMAX + 1) bits (48 here)
// a held result stalls the next bar in its last cycle until the result register frees
// reset is asynchronous active low; no memory clearing pass is needed
module multi_mode_moving_average #(
  parameter int MaxPeriod = mma_pkg::MAX_PERIOD_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [mma_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [mma_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                           sample_valid_i,
  output logic                           sample_ready_o,
  input  logic [mma_pkg::DATA_W-1:0]     sample_i,
  output logic                           result_valid_o,
  input  logic                           result_ready_i,
  output logic [mma_pkg::DATA_W-1:0]     average_o,
  output logic                           falling_o
);

  import mma_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  mma_ctrl u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .sample_valid_i (sample_valid_i),
    .sample_ready_o (sample_ready_o),
    .stat_i         (stat),
    .cmd_o          (cmd)
  );

  mma_dp #(
    .MaxPeriod (MaxPeriod)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .sample_i       (sample_i),
    .result_valid_o (result_valid_o),
    .result_ready_i (result_ready_i),
    .average_o      (average_o),
    .falling_o      (falling_o),
    .cmd_i          (cmd),
    .stat_o         (stat)
  );

endmodule

### rtl/mma_checker.sv
// port-level checks of the moving average, bound to the top level
`include "multi_mode_moving_average_macros.svh"

module mma_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic sample_valid_i,
  input logic sample_ready_o,
  input logic result_valid_o,
  input logic result_ready_i
);

  `MMA_ASSERT_RST(a_no_result_in_reset, !rst_ni |-> !result_valid_o, "result valid during reset")
  `MMA_ASSERT(a_result_held, result_valid_o && !result_ready_i |=> result_valid_o, "result dropped")
  `MMA_ASSERT(a_busy_after_take, sample_valid_i && sample_ready_o |=> !sample_ready_o, "ready after transaction")
  `MMA_ASSERT(a_result_from_work, $rose(result_valid_o) |-> $past(!sample_ready_o), "result without work")

endmodule

bind multi_mode_moving_average mma_checker u_mma_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .sample_valid_i (sample_valid_i),
  .sample_ready_o (sample_ready_o),
  .result_valid_o (result_valid_o),
  .result_ready_i (result_ready_i)
);

### tb/tb_multi_mode_moving_average.sv
// testbench for the multi-mode moving average: random price bars checked against a built-in predictor
module tb_multi_mode_moving_average;
  timeunit 1ns;
  timeprecision 1ps;

  import mma_pkg::*;

  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 2'd3;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int LONG_HOLD      = 300;
  localparam int DRAIN_CYCLES   = 4;
  localparam int SETTLE_CYCLES  = 80;
  localparam int RANDOM_BARS    = 1600;

  typedef struct packed {
    logic [DATA_W-1:0] average;
    logic              falling;
  } bar_result_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;
  logic                  sample_valid_i = 1'b0;
  logic                  sample_ready_o;
  logic [DATA_W-1:0]     sample_i = '0;
  logic                  result_valid_o;
  logic                  result_ready_i = 1'b0;
  logic [DATA_W-1:0]     average_o;
  logic                  falling_o;

  multi_mode_moving_average dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .sample_valid_i (sample_valid_i),
    .sample_ready_o (sample_ready_o),
    .sample_i       (sample_i),
    .result_valid_o (result_valid_o),
    .result_ready_i (result_ready_i),
    .average_o      (average_o),
    .falling_o      (falling_o)
  );

  always #6 clk_i = ~clk_i;

  logic [DATA_W-1:0] pending_samples[$];
  bar_result_t       expected_bars[$];

  // predictor state
  logic [PERIOD_W-1:0] mirror_period = PERIOD_RESET;
  method_e             mirror_method = METH_SMA;
  logic [DATA_W-1:0]   price_hist [MAX_PERIOD_DEF];
  logic [7:0]          hist_wr = '0;
  int unsigned         bars_seen = 0;
  logic [DATA_W-1:0]   prev_average = '0;

  bit          idle_enable = 1'b1;
  int          src_gap = 0;
  int          sink_gap = 0;
  int          hold_left = 0;
  int          holds_requested = 0;
  int          holds_served = 0;
  int          fail_count = 0;
  int          stuck_cycles = 0;
  int unsigned bars_queued = 0;
  logic [DATA_W-1:0] walk_price = 32'h0064_0000;

  function automatic void predict_bar(input logic [DATA_W-1:0] price);
    logic [PERIOD_W-1:0] p;
    logic [63:0]         sum;
    logic [63:0]         wsum;
    logic [63:0]         alpha;
    logic [63:0]         acc;
    logic [DATA_W-1:0]   avg;
    logic [7:0]          slot;
    int unsigned         n;
    int                  k;
    bar_result_t         res;
    if (mirror_period == '0) p = 9'd1;
    else if (mirror_period > MAX_PERIOD_DEF) p = PERIOD_W'(MAX_PERIOD_DEF);
    else p = mirror_period;
    n = bars_seen;
    price_hist[hist_wr] = price;
    hist_wr = hist_wr + 8'd1;
    sum = '0;
    wsum = '0;
    if (n >= p) begin
      for (k = 0; k < p; k++) begin
        slot = hist_wr - 8'd1 - 8'(k);
        sum  = sum + 64'(price_hist[slot]);
        wsum = wsum + 64'(price_hist[slot]) * 64'(p - k);
      end
    end
    case (mirror_method)
      METH_SMA: begin
        avg = (n < p) ? price : DATA_W'(sum / 64'(p));
      end
      METH_EMA: begin
        if (n == 0) begin
          avg = price;
        end else begin
          alpha = 64'(EMA_NUM) / (64'(p) + 64'd1);
          acc = 64'(price) * alpha + 64'(prev_average) * (64'(EMA_ONE) - alpha);
          avg = DATA_W'(acc >> EMA_SHIFT);
        end
      end
      METH_SMMA: begin
        if (n < p) avg = '0;
        else if (n == p) avg = DATA_W'(sum / 64'(p));
        else avg = DATA_W'((64'(prev_average) * 64'(p - 1) + 64'(price)) / 64'(p));
      end
      default: begin
        avg = (n < p) ? price : DATA_W'(wsum / ((64'(p) * (64'(p) + 64'd1)) / 64'd2));
      end
    endcase
    res.average = avg;
    res.falling = (avg < prev_average);
    expected_bars.push_back(res);
    prev_average = avg;
    if (bars_seen < MAX_PERIOD_DEF + 1) bars_seen++;
  endfunction

  function automatic void check_bar(input logic [DATA_W-1:0] avg, input logic fall);
    bar_result_t want;
    if (expected_bars.size() == 0) begin
      fail_count++;
      if (fail_count <= 10) begin
        $display("unexpected transaction: average %h falling %b", avg, fall);
      end
    end else begin
      want = expected_bars.pop_front();
      if (want.average !== avg || want.falling !== fall) begin
        fail_count++;
        if (fail_count <= 10) begin
          $display("mismatch: average exp %h got %h, falling exp %b got %b",
                   want.average, avg, want.falling, fall);
        end
      end
    end
  endfunction

  // sample driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sample_valid_i <= 1'b0;
      sample_i       <= '0;
    end else begin
      if (sample_valid_i && sample_ready_o) predict_bar(sample_i);
      if (!sample_valid_i || sample_ready_o) begin
        if (src_gap > 0) begin
          src_gap--;
          sample_valid_i <= 1'b0;
        end else if (idle_enable && pending_samples.size() != 0 && $urandom_range(0, 5) == 0) begin
          src_gap = $urandom_range(1, 11) - 1;
          sample_valid_i <= 1'b0;
        end else if (pending_samples.size() != 0) begin
          sample_valid_i <= 1'b1;
          sample_i       <= pending_samples.pop_front();
        end else begin
          sample_valid_i <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      result_ready_i <= 1'b0;
    end else begin
      if (result_valid_o && result_ready_i) check_bar(average_o, falling_o);
      if (holds_served != holds_requested) begin
        holds_served++;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        result_ready_i <= 1'b0;
      end else if (sink_gap > 0) begin
        sink_gap--;
        result_ready_i <= 1'b0;
      end else if (idle_enable && $urandom_range(0, 7) == 0) begin
        sink_gap = $urandom_range(1, 11) - 1;
        result_ready_i <= 1'b0;
      end else begin
        result_ready_i <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    if ((sample_valid_i && sample_ready_o) || (result_valid_o && result_ready_i)) begin
      stuck_cycles <= 0;
    end else if (pending_samples.size() != 0 || sample_valid_i || expected_bars.size() != 0) begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

  initial begin : watchdog
    wait (stuck_cycles >= WATCHDOG_LIMIT);
    $display("== FAIL ==");
    $finish;
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CFG_PERIOD: mirror_period = data;
      CFG_METHOD: mirror_method = method_e'(data[METHOD_W-1:0]);
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  task automatic wait_drained();
    while (pending_samples.size() != 0 || sample_valid_i || expected_bars.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  function automatic void queue_price(input logic [DATA_W-1:0] price);
    pending_samples.push_back(price);
    bars_queued++;
  endfunction

  function automatic logic [DATA_W-1:0] next_price();
    case ($urandom_range(0, 9))
      0: walk_price = '0;
      1: walk_price = '1;
      2, 3: walk_price = $urandom();
      default: walk_price = walk_price + DATA_W'($urandom_range(0, 131072)) - 32'd65536;
    endcase
    return walk_price;
  endfunction

  task automatic run_phase(input int count);
    repeat (count) queue_price(next_price());
    wait_drained();
  endtask

  initial begin : stimulus
    logic [CFG_DATA_W-1:0] new_period;
    int                    count;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // first bar seeds the exponential average
    write_reg(CFG_METHOD, CFG_DATA_W'(METH_EMA));
    queue_price('1);
    queue_price('0);
    queue_price('1);
    queue_price(32'h0000_0001);
    wait_drained();

    // zero period acts as one
    write_reg(CFG_METHOD, CFG_DATA_W'(METH_SMMA));
    write_reg(CFG_PERIOD, 9'd0);
    queue_price('1);
    queue_price(32'h0001_0000);
    wait_drained();

    // smoothed warm-up, first mean, then recursion
    write_reg(CFG_PERIOD, 9'd8);
    queue_price('0);
    queue_price('1);
    queue_price('1);
    queue_price(32'h1234_5678);
    wait_drained();

    // writes to unused indexes are ignored
    write_reg(CFG_SPARE_LO, '1);
    write_reg(CFG_SPARE_HI, '0);
    write_reg(CFG_METHOD, CFG_DATA_W'(METH_SMA));
    write_reg(CFG_PERIOD, 9'd12);
    queue_price('1);
    queue_price('0);
    queue_price('1);
    wait_drained();

    write_reg(CFG_METHOD, CFG_DATA_W'(METH_LWMA));
    write_reg(CFG_PERIOD, 9'd15);
    queue_price('0);
    queue_price('1);
    queue_price('1);
    queue_price('0);
    wait_drained();

    // period above the maximum is clamped
    write_reg(CFG_PERIOD, '1);
    queue_price('1);
    queue_price(32'h0000_0001);
    wait_drained();

    // full-size smoothed window, with a long receiver stall up front
    write_reg(CFG_METHOD, CFG_DATA_W'(METH_SMMA));
    write_reg(CFG_PERIOD, CFG_DATA_W'(MAX_PERIOD_DEF));
    holds_requested++;
    run_phase(240);

    while (bars_queued < RANDOM_BARS) begin
      if ($urandom_range(0, 1) == 1) begin
        if ($urandom_range(0, 7) == 0) begin
          case ($urandom_range(0, 5))
            0: new_period = 9'd0;
            1: new_period = 9'd1;
            2: new_period = 9'd255;
            3: new_period = 9'd256;
            4: new_period = 9'd257;
            default: new_period = '1;
          endcase
        end else begin
          new_period = CFG_DATA_W'($urandom_range(1, 24));
        end
        write_reg(CFG_PERIOD, new_period);
      end
      if ($urandom_range(0, 1) == 1) write_reg(CFG_METHOD, CFG_DATA_W'($urandom()));
      if ($urandom_range(0, 5) == 0) begin
        write_reg($urandom_range(0, 1) ? CFG_SPARE_LO : CFG_SPARE_HI, CFG_DATA_W'($urandom()));
      end
      idle_enable = ($urandom_range(0, 3) != 0);
      if ($urandom_range(0, 9) == 0) holds_requested++;
      count = (mirror_period >= 128) ? $urandom_range(4, 16) : $urandom_range(10, 60);
      run_phase(count);
    end

    idle_enable = 1'b0;
    write_reg(CFG_PERIOD, CFG_DATA_W'($urandom_range(1, 20)));
    write_reg(CFG_METHOD, CFG_DATA_W'($urandom()));
    run_phase(150);

    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (fail_count == 0 && expected_bars.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

### files.f
+incdir+rtl
rtl/mma_pkg.sv
rtl/mma_div.sv
rtl/mma_ctrl.sv
rtl/mma_dp.sv
rtl/multi_mode_moving_average.sv
rtl/mma_checker.sv
tb/tb_multi_mode_moving_average.sv
